// ===== design/ops_pkg.sv =====
`default_nettype none

package ops_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int FRAC_BITS   = 4;
    localparam int LIMIT_WIDTH = 10;
    localparam int TDATA_WIDTH = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int MAX_RESULTS = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [LIMIT_WIDTH-1:0]        limit_t;
    typedef logic [1:0]                    count_t;

    localparam limit_t NEAR_RESET = LIMIT_WIDTH'(1 << FRAC_BITS);

    // configuration register indexes
    typedef enum logic {
        REG_BEND_VERT  = 1'b0,
        REG_NEAR_LIMIT = 1'b1
    } reg_index_t;

    // path tracking phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,   // no path started
        PH_ONE  = 3'b010,   // first point seen
        PH_TWO  = 3'b100    // candidate point pending
    } phase_t;

    typedef struct packed {
        logic   path_end;
        coord_t y;
        coord_t x;
    } result_t;

    // |a - b| < lim, exact
    function automatic logic near_f(coord_t a, coord_t b, limit_t lim);
        logic signed [COORD_WIDTH:0] d;
        logic [COORD_WIDTH:0]        m;
        d = (COORD_WIDTH+1)'(a) - (COORD_WIDTH+1)'(b);
        m = d[COORD_WIDTH] ? (COORD_WIDTH+1)'(-d) : (COORD_WIDTH+1)'(d);
        return m < (COORD_WIDTH+1)'(lim);
    endfunction

endpackage

`default_nettype wire

// ===== design/orthogonal_path_snapper_top.sv =====
`default_nettype none

// Orthogonal path snapper: takes the points of a polyline (s_tlast on the final
// point) and streams out the rectified polyline. Where both coordinates change
// by at least near_limit an L-bend corner goes in first (bend_vert picks
// which corner), then middle points that line up with their neighbors in x or
// in y are dropped; the first and last points always come out. m_tlast marks
// the final point of a path, m_tuser the last result caused by one input point.
// Flow: an accepted point is held in an input register, then processed into
// a three-slot result buffer, and its results leave one per cycle while
// m_tready is high, the first once the point has passed through the input
// register and the result buffer. The single-result output channel sets the
// sustained rate. The input register takes the next point while the buffer
// drains and holds it until the last result of the previous point leaves, so
// the next point's results follow the previous ones with no gap.
// Configuration writes are taken at any time but should only be issued while
// the block is idle.
module orthogonal_path_snapper_top (
    input  wire                                clk,
    input  wire                                rst_n,
    // configuration write port
    input  wire                                cfg_we,
    input  wire                                cfg_index,
    input  wire [ops_pkg::LIMIT_WIDTH-1:0]     cfg_data,
    // input points
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [ops_pkg::TDATA_WIDTH-1:0]     s_tdata,   // pt_x, pt_y
    input  wire                                s_tlast,   // final_point
    // rectified points
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [ops_pkg::TDATA_WIDTH-1:0]    m_tdata,   // out_x, out_y
    output logic                               m_tlast,   // path_end
    output logic                               m_tuser    // run_last
);
    import ops_pkg::*;

    // configuration
    logic   bend_vert_reg;
    limit_t near_limit_reg;

    // input register
    logic   in_valid_reg;
    coord_t in_x_reg, in_y_reg;
    logic   in_fin_reg;

    // path state
    phase_t phase_reg, phase_next;
    coord_t kept_x_reg, kept_y_reg, kept_x_next, kept_y_next;
    coord_t pend_x_reg, pend_y_reg, pend_x_next, pend_y_next;

    // result buffer, slot 0 is at the output
    result_t slot_reg [MAX_RESULTS];
    result_t slot_next [MAX_RESULTS];
    count_t  buf_left_reg, buf_left_next;

    logic   pop, proc;
    result_t new_res [MAX_RESULTS];
    count_t  new_cnt;

    // per-point working values
    logic   first_pt, bend, emit1, emit2;
    coord_t lx, ly, q1x, q1y, k1x, k1y;

    assign pop      = m_tvalid && m_tready;
    assign proc     = in_valid_reg &&
                      ((buf_left_reg == 2'd0) || ((buf_left_reg == 2'd1) && m_tready));
    assign s_tready = !in_valid_reg || proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bend_vert_reg  <= 1'b1;
            near_limit_reg <= NEAR_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_BEND_VERT:  bend_vert_reg  <= cfg_data[0];
                REG_NEAR_LIMIT: near_limit_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_x_reg   <= s_tdata[COORD_WIDTH-1:0];
            in_y_reg   <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
            in_fin_reg <= s_tlast;
        end
    end

    // One point through bend insertion and thinning. At most two thinning
    // decisions (bend corner, then the point) plus the end-of-path flush.
    always_comb
    begin
        phase_next  = phase_reg;
        kept_x_next = kept_x_reg;
        kept_y_next = kept_y_reg;
        pend_x_next = pend_x_reg;
        pend_y_next = pend_y_reg;

        first_pt = (phase_reg == PH_IDLE);
        lx = (phase_reg == PH_ONE) ? kept_x_reg : pend_x_reg;
        ly = (phase_reg == PH_ONE) ? kept_y_reg : pend_y_reg;
        bend = !near_f(in_x_reg, lx, near_limit_reg) &&
               !near_f(in_y_reg, ly, near_limit_reg);

        // first point fed to thinning: corner if any, else the point itself
        if (bend)
        begin
            q1x = bend_vert_reg ? lx : in_x_reg;
            q1y = bend_vert_reg ? in_y_reg : ly;
        end
        else
        begin
            q1x = in_x_reg;
            q1y = in_y_reg;
        end

        // feeding q1: only a pending candidate can be emitted
        emit1 = 1'b0;
        case (phase_reg)
            PH_IDLE, PH_ONE: emit1 = 1'b0;
            default:
                emit1 = !((near_f(kept_x_reg, pend_x_reg, near_limit_reg) &&
                           near_f(pend_x_reg, q1x, near_limit_reg)) ||
                          (near_f(kept_y_reg, pend_y_reg, near_limit_reg) &&
                           near_f(pend_y_reg, q1y, near_limit_reg)));
        endcase
        k1x = emit1 ? pend_x_reg : kept_x_reg;
        k1y = emit1 ? pend_y_reg : kept_y_reg;

        // feeding the point after a corner: candidate is now the corner
        emit2 = bend &&
                !((near_f(k1x, q1x, near_limit_reg) &&
                   near_f(q1x, in_x_reg, near_limit_reg)) ||
                  (near_f(k1y, q1y, near_limit_reg) &&
                   near_f(q1y, in_y_reg, near_limit_reg)));

        if (first_pt)
        begin
            if (!in_fin_reg)
            begin
                kept_x_next = in_x_reg;
                kept_y_next = in_y_reg;
                phase_next  = PH_ONE;
            end
        end
        else if (in_fin_reg)
        begin
            phase_next  = PH_IDLE;
            kept_x_next = '0;
            kept_y_next = '0;
            pend_x_next = '0;
            pend_y_next = '0;
        end
        else
        begin
            phase_next  = PH_TWO;
            kept_x_next = emit2 ? q1x : k1x;
            kept_y_next = emit2 ? q1y : k1y;
            pend_x_next = in_x_reg;
            pend_y_next = in_y_reg;
        end

        // pack the results in order
        new_cnt = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
            new_res[i] = '{path_end: 1'b0, y: '0, x: '0};
        if (first_pt)
        begin
            new_res[0] = '{path_end: in_fin_reg, y: in_y_reg, x: in_x_reg};
            new_cnt    = 2'd1;
        end
        else
        begin
            if (emit1)
            begin
                new_res[new_cnt] = '{path_end: 1'b0, y: pend_y_reg, x: pend_x_reg};
                new_cnt = new_cnt + 2'd1;
            end
            if (emit2)
            begin
                new_res[new_cnt] = '{path_end: 1'b0, y: q1y, x: q1x};
                new_cnt = new_cnt + 2'd1;
            end
            if (in_fin_reg)
            begin
                new_res[new_cnt] = '{path_end: 1'b1, y: in_y_reg, x: in_x_reg};
                new_cnt = new_cnt + 2'd1;
            end
        end
    end

    // result buffer: load when drained or its last result leaves, otherwise shift toward the output
    always_comb
    begin
        buf_left_next = buf_left_reg;
        for (int i = 0; i < MAX_RESULTS; i++)
            slot_next[i] = slot_reg[i];
        if (proc)
        begin
            buf_left_next = new_cnt;
            for (int i = 0; i < MAX_RESULTS; i++)
                slot_next[i] = new_res[i];
        end
        else if (pop)
        begin
            buf_left_next = buf_left_reg - 2'd1;
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                slot_next[i] = slot_reg[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            kept_x_reg   <= '0;
            kept_y_reg   <= '0;
            pend_x_reg   <= '0;
            pend_y_reg   <= '0;
            buf_left_reg <= '0;
        end
        else
        begin
            if (proc)
            begin
                phase_reg  <= phase_next;
                kept_x_reg <= kept_x_next;
                kept_y_reg <= kept_y_next;
                pend_x_reg <= pend_x_next;
                pend_y_reg <= pend_y_next;
            end
            buf_left_reg <= buf_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
            slot_reg[i] <= slot_next[i];
    end

    assign m_tvalid = (buf_left_reg != 2'd0);
    assign m_tdata  = TDATA_WIDTH'({slot_reg[0].y, slot_reg[0].x});
    assign m_tlast  = slot_reg[0].path_end;
    assign m_tuser  = (buf_left_reg == 2'd1);

    // a path end is always the last result of its point
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("path end not marked as last result of its point");

    // a final point always returns the tracker to idle
    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_fin_reg |=> phase_reg == PH_IDLE)
        else $error("tracker not idle after final point");

    // a held point is processed only once the buffer has drained or its last result is leaving
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        proc |-> (buf_left_reg == 2'd0) || (buf_left_reg == 2'd1 && pop))
        else $error("result buffer overwritten");

endmodule

`default_nettype wire
